FILE: rtl/assert_macros.svh
// assertion macros shared by the rtl modules
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// implication checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: rtl/hidke_pkg.sv
// shared types, constants and tables for the hid report to key event block
// no dependencies
package hidke_pkg;

  localparam int BootKeySlots     = 6;
  localparam int ConsumerKeySlots = 4;
  localparam int ModifierBits     = 8;
  localparam int MaxReportBytes   = 16;
  localparam int MaxResults       = 24;
  localparam int BitmaskBits      = 24;

  localparam logic [2:0] REG_BOOT_EP    = 3'd0;
  localparam logic [2:0] REG_BOOT_ID    = 3'd1;
  localparam logic [2:0] REG_CONS_EP    = 3'd2;
  localparam logic [2:0] REG_CONS_ID    = 3'd3;
  localparam logic [2:0] REG_CONS_COUNT = 3'd4;
  localparam logic [2:0] REG_CONS_STYLE = 3'd5;
  localparam logic [2:0] REG_MOD_BASE   = 3'd6;
  localparam logic [2:0] REG_CONS_OFS   = 3'd7;

  typedef struct packed {
    logic [3:0]  endpoint;
    logic [4:0]  report_length;
    logic [63:0] report_low;
    logic [63:0] report_high;
  } in_req_t;

  typedef struct packed {
    logic [16:0] key_code;
    logic        pressed;
    logic        last_event;
  } out_req_t;

  typedef struct packed {
    logic [3:0] boot_endpoint;
    logic [7:0] boot_report_id;
    logic [3:0] consumer_endpoint;
    logic [7:0] consumer_report_id;
    logic [4:0] consumer_key_count;
    logic       consumer_style;
    logic [7:0] modifier_base;
    logic [9:0] consumer_offset;
  } cfg_regs_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_FLUSH,
    ST_DONE
  } ctrl_state_t;

  // datapath phases
  typedef enum logic [2:0] {
    PH_MOD,
    PH_BOOT_PRESS,
    PH_BOOT_REL,
    PH_CONS_PRESS,
    PH_CONS_REL,
    PH_SINGLE,
    PH_MASK,
    PH_END
  } phase_t;

  typedef struct packed {
    logic load;
    logic step;
    logic flush;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic hold_full;
    logic pend_valid;
  } dp_status_t;

  function automatic logic [9:0] bitmask_usage(input logic [4:0] idx);
    logic [9:0] u;
    case (idx)
      5'd0:  u = 10'h0b5;
      5'd1:  u = 10'h0b6;
      5'd2:  u = 10'h0b7;
      5'd3:  u = 10'h0cd;
      5'd4:  u = 10'h0e2;
      5'd5:  u = 10'h0e5;
      5'd6:  u = 10'h0e7;
      5'd7:  u = 10'h0e9;
      5'd8:  u = 10'h0ea;
      5'd9:  u = 10'h152;
      5'd10: u = 10'h153;
      5'd11: u = 10'h154;
      5'd12: u = 10'h155;
      5'd13: u = 10'h183;
      5'd14: u = 10'h18a;
      5'd15: u = 10'h192;
      5'd16: u = 10'h194;
      5'd17: u = 10'h221;
      5'd18: u = 10'h223;
      5'd19: u = 10'h224;
      5'd20: u = 10'h225;
      5'd21: u = 10'h226;
      5'd22: u = 10'h227;
      5'd23: u = 10'h22a;
      default: u = 10'h000;
    endcase
    return u;
  endfunction

endpackage

FILE: rtl/hid_report_to_key_events.sv
// usb hid report to key event converter, top level
// depends on hidke_pkg, hidke_ctrl and hidke_dp
//
// usage: a report (endpoint, length, 16 bytes) is taken on the in_ channel
// with a valid/ready request. it is routed to the boot keyboard or the
// consumer path by endpoint and report id and compared with the stored key
// state. each change gives one result on the out_ channel (key code and
// press flag); the final result of a report carries last_event.
// output order: an event waits in a pending register until the next event or the
// end of the scan, and only then moves to the output register, so the first
// result shows no later than the end of the scan.
// scan steps: a report takes 8 + 2 x slots steps for boot reports, 2 x slots
// for consumer lists, 2 for single usage, 24 for bitmask reports and none
// for unmatched reports. in_ready is high only between reports, so a new
// report is taken only after the last one is through.
// a stalled receiver freezes the scan at the next event while one is pending;
// the result in the output register holds until taken, with no event lost.
// reset: synchronous active low; clears all key state and loads register
// defaults. config writes on cfg_ must only be made between reports.
module hid_report_to_key_events #(
  parameter int BOOT_KEY_SLOTS     = hidke_pkg::BootKeySlots,
  parameter int CONSUMER_KEY_SLOTS = hidke_pkg::ConsumerKeySlots,
  parameter int MODIFIER_BITS      = hidke_pkg::ModifierBits,
  parameter int MAX_REPORT_BYTES   = hidke_pkg::MaxReportBytes
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [9:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  hidke_pkg::in_req_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output hidke_pkg::out_req_t out_data
);

  hidke_pkg::dp_cmd_t    cmd;
  hidke_pkg::dp_status_t status;

  hidke_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  hidke_dp #(
    .BOOT_KEY_SLOTS     (BOOT_KEY_SLOTS),
    .CONSUMER_KEY_SLOTS (CONSUMER_KEY_SLOTS),
    .MODIFIER_BITS      (MODIFIER_BITS),
    .MAX_REPORT_BYTES   (MAX_REPORT_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/hidke_ctrl.sv
// controller state machine for the hid report to key event block
// depends on hidke_pkg and assert_macros.svh
`include "assert_macros.svh"
module hidke_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  hidke_pkg::dp_status_t status,
  output hidke_pkg::dp_cmd_t    cmd
);

  hidke_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hidke_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hidke_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = hidke_pkg::ST_LOAD;
        end
      end
      hidke_pkg::ST_LOAD: state_nxt = hidke_pkg::ST_SCAN;
      hidke_pkg::ST_SCAN: begin
        if (status.scan_done) begin
          state_nxt = hidke_pkg::ST_FLUSH;
        end
      end
      hidke_pkg::ST_FLUSH: begin
        if (!status.hold_full) begin
          state_nxt = hidke_pkg::ST_DONE;
        end
      end
      hidke_pkg::ST_DONE: state_nxt = hidke_pkg::ST_IDLE;
      default: state_nxt = hidke_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      hidke_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      hidke_pkg::ST_SCAN:  cmd.step  = 1'b1;
      hidke_pkg::ST_FLUSH: cmd.flush = 1'b1;
      default: ;
    endcase
  end

  `ASSERT_IMPL(a_ready_idle, clk, rst_n, in_ready, state_r == hidke_pkg::ST_IDLE)
  `ASSERT_NEXT(a_load_scan, clk, rst_n, state_r == hidke_pkg::ST_LOAD, state_r == hidke_pkg::ST_SCAN)
  `ASSERT_IMPL(a_one_cmd, clk, rst_n, 1'b1, $onehot0({cmd.load, cmd.step, cmd.flush}))

endmodule

FILE: rtl/hidke_dp.sv
// datapath: config registers, key state, event scan and output register
// depends on hidke_pkg and assert_macros.svh
`include "assert_macros.svh"
module hidke_dp #(
  parameter int BOOT_KEY_SLOTS     = hidke_pkg::BootKeySlots,
  parameter int CONSUMER_KEY_SLOTS = hidke_pkg::ConsumerKeySlots,
  parameter int MODIFIER_BITS      = hidke_pkg::ModifierBits,
  parameter int MAX_REPORT_BYTES   = hidke_pkg::MaxReportBytes
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [9:0]            cfg_data,
  input  hidke_pkg::in_req_t    in_data,
  input  hidke_pkg::dp_cmd_t    cmd,
  output hidke_pkg::dp_status_t status,
  output logic                  out_valid,
  input  logic                  out_ready,
  output hidke_pkg::out_req_t   out_data
);

  localparam int NB = MAX_REPORT_BYTES;
  localparam int CW = 5;
  localparam int BIW = (BOOT_KEY_SLOTS > 1) ? $clog2(BOOT_KEY_SLOTS) : 1;
  localparam int CIW = (CONSUMER_KEY_SLOTS > 1) ? $clog2(CONSUMER_KEY_SLOTS) : 1;

  hidke_pkg::cfg_regs_t cfg_r;
  logic [7:0]  mods_r;
  logic [7:0]  bkeys_r [BOOT_KEY_SLOTS];
  logic [15:0] ckeys_r [CONSUMER_KEY_SLOTS];
  logic [23:0] mask_r;
  logic [7:0]  nb_r [BOOT_KEY_SLOTS];
  logic [15:0] nc_r [CONSUMER_KEY_SLOTS];
  logic [3:0]  nbn_r;
  logic [2:0]  ncn_r;
  logic [23:0] nmask_r;
  logic [7:0]  nmods_r;
  hidke_pkg::phase_t ph_r;
  logic [CW-1:0] idx_r;
  logic [4:0] cnt_r;
  logic pend_r;
  logic [16:0] pcode_r;
  logic ppress_r;
  logic ov_r;
  hidke_pkg::out_req_t od_r;

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.boot_endpoint      <= 4'd1;
      cfg_r.boot_report_id     <= 8'd0;
      cfg_r.consumer_endpoint  <= 4'd0;
      cfg_r.consumer_report_id <= 8'd0;
      cfg_r.consumer_key_count <= 5'd1;
      cfg_r.consumer_style     <= 1'b0;
      cfg_r.modifier_base      <= 8'd224;
      cfg_r.consumer_offset    <= 10'd255;
    end else if (cfg_we) begin
      case (cfg_index)
        hidke_pkg::REG_BOOT_EP:    cfg_r.boot_endpoint      <= cfg_data[3:0];
        hidke_pkg::REG_BOOT_ID:    cfg_r.boot_report_id     <= cfg_data[7:0];
        hidke_pkg::REG_CONS_EP:    cfg_r.consumer_endpoint  <= cfg_data[3:0];
        hidke_pkg::REG_CONS_ID:    cfg_r.consumer_report_id <= cfg_data[7:0];
        hidke_pkg::REG_CONS_COUNT: cfg_r.consumer_key_count <= cfg_data[4:0];
        hidke_pkg::REG_CONS_STYLE: cfg_r.consumer_style     <= cfg_data[0];
        hidke_pkg::REG_MOD_BASE:   cfg_r.modifier_base      <= cfg_data[7:0];
        hidke_pkg::REG_CONS_OFS:   cfg_r.consumer_offset    <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // route the raw report: bytes with length masking
  logic [4:0] len_c;
  logic [7:0] raw_c [NB];
  logic [7:0] b0_c;
  always_comb begin
    len_c = (in_data.report_length > 5'(NB)) ? 5'(NB) : in_data.report_length;
    for (int i = 0; i < NB; i++) begin
      if (i < 8) begin
        raw_c[i] = in_data.report_low[8*i +: 8];
      end else begin
        raw_c[i] = in_data.report_high[8*(i-8) +: 8];
      end
      if (5'(i) >= len_c) begin
        raw_c[i] = 8'd0;
      end
    end
    b0_c = raw_c[0];
  end

  logic boot_c, cons_c, off_c;
  logic [4:0] dlen_c;
  logic [7:0] d_c [NB];
  hidke_pkg::phase_t ph0_c;
  always_comb begin
    boot_c = (len_c != 5'd0) && (in_data.endpoint == cfg_r.boot_endpoint) &&
      ((cfg_r.boot_report_id == 8'd0) || (cfg_r.boot_report_id == b0_c));
    cons_c = (len_c != 5'd0) && !boot_c && (cfg_r.consumer_endpoint != 4'd0) &&
      (in_data.endpoint == cfg_r.consumer_endpoint) &&
      ((cfg_r.consumer_report_id == 8'd0) || (cfg_r.consumer_report_id == b0_c));
    off_c = boot_c ? (cfg_r.boot_report_id != 8'd0) : (cfg_r.consumer_report_id != 8'd0);
    dlen_c = len_c - 5'(off_c);
    for (int i = 0; i < NB; i++) begin
      if (off_c) begin
        d_c[i] = (i + 1 < NB) ? raw_c[(i + 1) % NB] : 8'd0;
      end else begin
        d_c[i] = raw_c[i];
      end
    end
    ph0_c = hidke_pkg::PH_END;
    if (boot_c) begin
      ph0_c = hidke_pkg::PH_MOD;
    end else if (cons_c) begin
      if (!cfg_r.consumer_style && dlen_c >= 5'd2) begin
        ph0_c = (cfg_r.consumer_key_count == 5'd1) ? hidke_pkg::PH_SINGLE
                                                   : hidke_pkg::PH_CONS_PRESS;
      end else if (cfg_r.consumer_style && dlen_c == 5'd3) begin
        ph0_c = hidke_pkg::PH_MASK;
      end
    end
  end

  // per-step event search
  logic        ev_c;
  logic [16:0] evcode_c;
  logic        evpress_c;
  logic        last_c;
  logic [CW-1:0] idx_nxt;
  hidke_pkg::phase_t ph_nxt;
  logic        fb_c, fc_c;
  logic [7:0]  bk_c;
  logic [15:0] ck_c;
  always_comb begin
    ev_c = 1'b0;
    evcode_c = '0;
    evpress_c = 1'b0;
    last_c = 1'b0;
    idx_nxt = idx_r + CW'(1);
    ph_nxt = ph_r;
    fb_c = 1'b0;
    fc_c = 1'b0;
    bk_c = '0;
    ck_c = '0;
    case (ph_r)
      hidke_pkg::PH_MOD: begin
        if (mods_r[idx_r[2:0]] != nmods_r[idx_r[2:0]]) begin
          ev_c = 1'b1;
        end
        evcode_c = 17'(cfg_r.modifier_base) + 17'(idx_r);
        evpress_c = nmods_r[idx_r[2:0]];
        if (idx_r == CW'(MODIFIER_BITS - 1)) begin
          last_c = 1'b1;
        end
      end
      hidke_pkg::PH_BOOT_PRESS: begin
        bk_c = nb_r[idx_r[BIW-1:0]];
        for (int j = 0; j < BOOT_KEY_SLOTS; j++) begin
          if (bkeys_r[j] == bk_c) fb_c = 1'b1;
        end
        ev_c = (4'(idx_r) < nbn_r) && bk_c != 8'd0 && !fb_c;
        evcode_c = 17'(bk_c);
        evpress_c = 1'b1;
        last_c = (idx_r == CW'(BOOT_KEY_SLOTS - 1));
      end
      hidke_pkg::PH_BOOT_REL: begin
        bk_c = bkeys_r[idx_r[BIW-1:0]];
        for (int j = 0; j < BOOT_KEY_SLOTS; j++) begin
          if (4'(j) < nbn_r && nb_r[j] == bk_c) fb_c = 1'b1;
        end
        ev_c = bk_c != 8'd0 && !fb_c;
        evcode_c = 17'(bk_c);
        last_c = (idx_r == CW'(BOOT_KEY_SLOTS - 1));
      end
      hidke_pkg::PH_CONS_PRESS: begin
        ck_c = nc_r[idx_r[CIW-1:0]];
        for (int j = 0; j < CONSUMER_KEY_SLOTS; j++) begin
          if (ckeys_r[j] == ck_c) fc_c = 1'b1;
        end
        ev_c = (3'(idx_r) < ncn_r) && ck_c != 16'd0 && !fc_c;
        evcode_c = 17'(ck_c) + 17'(cfg_r.consumer_offset);
        evpress_c = 1'b1;
        last_c = (idx_r == CW'(CONSUMER_KEY_SLOTS - 1));
      end
      hidke_pkg::PH_CONS_REL: begin
        ck_c = ckeys_r[idx_r[CIW-1:0]];
        for (int j = 0; j < CONSUMER_KEY_SLOTS; j++) begin
          if (3'(j) < ncn_r && nc_r[j] == ck_c) fc_c = 1'b1;
        end
        ev_c = ck_c != 16'd0 && !fc_c;
        evcode_c = 17'(ck_c) + 17'(cfg_r.consumer_offset);
        last_c = (idx_r == CW'(CONSUMER_KEY_SLOTS - 1));
      end
      hidke_pkg::PH_SINGLE: begin
        // step 0 releases old, step 1 presses new
        if (idx_r == CW'(0)) begin
          ck_c = ckeys_r[0];
          evpress_c = 1'b0;
        end else begin
          ck_c = nc_r[0];
          evpress_c = 1'b1;
        end
        ev_c = (nc_r[0] != ckeys_r[0]) && ck_c != 16'd0;
        evcode_c = 17'(ck_c) + 17'(cfg_r.consumer_offset);
        last_c = (idx_r == CW'(1));
      end
      hidke_pkg::PH_MASK: begin
        ev_c = mask_r[idx_r] != nmask_r[idx_r];
        evcode_c = 17'(hidke_pkg::bitmask_usage(idx_r)) + 17'(cfg_r.consumer_offset);
        evpress_c = nmask_r[idx_r];
        last_c = (idx_r == CW'(hidke_pkg::BitmaskBits - 1));
      end
      default: ;
    endcase
    if (last_c) begin
      idx_nxt = '0;
      case (ph_r)
        hidke_pkg::PH_MOD:        ph_nxt = hidke_pkg::PH_BOOT_PRESS;
        hidke_pkg::PH_BOOT_PRESS: ph_nxt = hidke_pkg::PH_BOOT_REL;
        hidke_pkg::PH_CONS_PRESS: ph_nxt = hidke_pkg::PH_CONS_REL;
        default:                  ph_nxt = hidke_pkg::PH_END;
      endcase
    end
  end

  logic stall_c, emit_c, take_c;
  logic flush_c, load_od_c, ov_nxt;
  assign take_c  = ev_c && cmd.step && ph_r != hidke_pkg::PH_END;
  assign stall_c = take_c && pend_r && ov_r && !out_ready;
  assign emit_c  = take_c && !stall_c && cnt_r < 5'(hidke_pkg::MaxResults);

  assign status.scan_done  = (ph_r == hidke_pkg::PH_END);
  assign status.hold_full  = ov_r && !out_ready && pend_r;
  assign status.pend_valid = pend_r;

  assign flush_c   = !emit_c && cmd.flush && pend_r && !status.hold_full;
  assign load_od_c = (emit_c && pend_r) || flush_c;
  assign ov_nxt    = load_od_c || (ov_r && !out_ready);

  // pending event register ahead of the output register; last flag
  // is set once the scan shows no later event
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r   <= 1'b0;
      pend_r <= 1'b0;
      ph_r   <= hidke_pkg::PH_END;
      idx_r  <= '0;
      cnt_r  <= '0;
    end else begin
      ov_r <= ov_nxt;
      if (cmd.load) begin
        ph_r  <= ph0_c;
        idx_r <= '0;
        cnt_r <= '0;
      end else if (cmd.step && !stall_c && ph_r != hidke_pkg::PH_END) begin
        ph_r  <= ph_nxt;
        idx_r <= idx_nxt;
      end
      if (emit_c) begin
        cnt_r <= cnt_r + 5'd1;
        pend_r <= 1'b1;
        pcode_r <= evcode_c;
        ppress_r <= evpress_c;
        if (pend_r) begin
          od_r <= '{key_code: pcode_r, pressed: ppress_r, last_event: 1'b0};
        end
      end else if (flush_c) begin
        od_r <= '{key_code: pcode_r, pressed: ppress_r, last_event: 1'b1};
        pend_r <= 1'b0;
      end
    end
  end

  // key state and new-report capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mods_r <= '0;
      mask_r <= '0;
      for (int i = 0; i < BOOT_KEY_SLOTS; i++) bkeys_r[i] <= '0;
      for (int i = 0; i < CONSUMER_KEY_SLOTS; i++) ckeys_r[i] <= '0;
    end else if (cmd.load) begin
      nmods_r <= d_c[0];
      nmask_r <= {d_c[2], d_c[1], d_c[0]};
      for (int i = 0; i < BOOT_KEY_SLOTS; i++) begin
        nb_r[i] <= (i + 2 < NB) ? d_c[(i + 2) % NB] : 8'd0;
      end
      for (int i = 0; i < CONSUMER_KEY_SLOTS; i++) begin
        nc_r[i] <= (2*i + 1 < NB) ? {d_c[(2*i + 1) % NB], d_c[(2*i) % NB]} : 16'd0;
      end
      if (dlen_c < 5'd2) begin
        nbn_r <= '0;
      end else if (dlen_c - 5'd2 > 5'(BOOT_KEY_SLOTS)) begin
        nbn_r <= 4'(BOOT_KEY_SLOTS);
      end else begin
        nbn_r <= 4'(dlen_c - 5'd2);
      end
      if (dlen_c[4:1] > 4'(CONSUMER_KEY_SLOTS)) begin
        ncn_r <= 3'(CONSUMER_KEY_SLOTS);
      end else begin
        ncn_r <= 3'(dlen_c[4:1]);
      end
    end else if (cmd.step && !stall_c && last_c) begin
      case (ph_r)
        hidke_pkg::PH_MOD: mods_r <= nmods_r;
        hidke_pkg::PH_BOOT_REL: begin
          for (int i = 0; i < BOOT_KEY_SLOTS; i++) begin
            bkeys_r[i] <= (4'(i) < nbn_r) ? nb_r[i] : 8'd0;
          end
        end
        hidke_pkg::PH_CONS_REL: begin
          for (int i = 0; i < CONSUMER_KEY_SLOTS; i++) begin
            ckeys_r[i] <= (3'(i) < ncn_r) ? nc_r[i] : 16'd0;
          end
        end
        hidke_pkg::PH_SINGLE: ckeys_r[0] <= nc_r[0];
        hidke_pkg::PH_MASK: mask_r <= nmask_r;
        default: ;
      endcase
    end
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

  `ASSERT_IMPL(a_cnt_cap, clk, rst_n, 1'b1, cnt_r <= 5'(hidke_pkg::MaxResults))
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
  `ASSERT_IMPL(a_emit_room, clk, rst_n, emit_c && pend_r, !(ov_r && !out_ready))

endmodule
